/* src/dvc_pkg.sv */
// shared types and constants for the delta varint codec
package dvc_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned GroupBits  = 7;
	localparam int unsigned MaxGroups  = 10;
	localparam int unsigned CountWidth = 4;
	localparam int unsigned SlotWidth  = GroupBits * MaxGroups;
	localparam int unsigned ContBit    = 7;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef struct packed {
		logic busy;
		logic last;
	} enc_stat_t;

endpackage

/* src/dvc_enc.sv */
// byte serializer: shifts a 64-bit value out in 7-bit groups, one byte per cycle while advance is high
module dvc_enc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [63:0]                 load_data,
	input  logic                        advance,
	output logic [7:0]                  enc_byte,
	output dvc_pkg::enc_stat_t          stat
);
	import dvc_pkg::*;

	logic [ValueWidth-1:0] sh_q;
	logic                  busy_q;
	logic                  last;

	assign last     = (sh_q[ValueWidth-1:GroupBits] == '0);
	assign enc_byte = {~last, sh_q[GroupBits-1:0]};
	assign stat     = '{busy: busy_q, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (busy_q && advance && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= load_data;
		end else if (busy_q && advance) begin
			sh_q <= {{GroupBits{1'b0}}, sh_q[ValueWidth-1:GroupBits]};
		end
	end

`ifndef SYNTHESIS
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q) else $error("serializer loaded while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && advance && last && !load) |=> !busy_q)
		else $error("serializer still busy after last byte");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !advance && !load) |=> $stable(sh_q))
		else $error("serializer shifted without advance");
`endif

endmodule

/* src/delta_varint_codec.sv */
// top level of the delta varint codec: request handshake, decoder and output register
// Unsigned LEB128 varint codec with optional delta coding. A decode request carries one
// byte; requests are taken back to back while in_stall is low. The byte that ends a
// varint, or an eleventh byte (error), gives one result. An encode request loads a
// 64-bit shift register sent as n bytes (n from 1 to 10): the serializer emits one
// 7-bit group per cycle while the output is not stalled, and the next request waits
// until the last byte has left. A stalled output holds both sides; cfg_we writes delta_q.
module delta_varint_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [63:0] value,
	input  logic [7:0]  in_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        byte_last,
	output logic [63:0] value_out,
	output logic        value_valid,
	output logic        error
);
	import dvc_pkg::*;

	logic                  delta_q;
	logic [ValueWidth-1:0] prev_q;
	logic [ValueWidth-1:0] acc_q;
	logic [CountWidth-1:0] cnt_q;

	logic                  out_valid_q;
	logic [ByteWidth-1:0]  out_byte_q;
	logic                  byte_valid_q;
	logic                  byte_last_q;
	logic [ValueWidth-1:0] value_out_q;
	logic                  value_valid_q;
	logic                  error_q;

	logic                  out_free;
	logic                  in_acc;
	logic                  enc_load;
	logic                  dec_acc;
	logic                  enc_adv;
	logic [ValueWidth-1:0] prev_eff;
	logic [ValueWidth-1:0] acc_eff;
	logic [CountWidth-1:0] cnt_eff;
	logic [ValueWidth-1:0] enc_data;
	logic                  overflow;
	logic                  dec_final;
	logic [SlotWidth-1:0]  acc_wide;
	logic [ValueWidth-1:0] acc_ins;
	logic [ValueWidth-1:0] dec_sum;
	logic                  dec_result;
	logic [ByteWidth-1:0]  enc_byte;
	enc_stat_t             stat;

	dvc_enc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (enc_load),
		.load_data (enc_data),
		.advance   (out_free),
		.enc_byte  (enc_byte),
		.stat      (stat)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = stat.busy || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign enc_load = in_acc && (mode == MODE_ENCODE);
	assign dec_acc  = in_acc && (mode == MODE_DECODE);
	assign enc_adv  = stat.busy && out_free;

	assign prev_eff = first ? '0 : prev_q;
	assign acc_eff  = first ? '0 : acc_q;
	assign cnt_eff  = first ? '0 : cnt_q;
	assign enc_data = delta_q ? (value - prev_eff) : value;

	assign overflow  = (cnt_eff >= CountWidth'(MaxGroups));
	assign dec_final = !in_byte[ContBit];

	// drop the group into its slot; the tenth slot keeps only bit 63
	always_comb begin
		acc_wide = {{(SlotWidth - ValueWidth){1'b0}}, acc_eff};
		for (int k = 0; k < MaxGroups; k++) begin
			if (cnt_eff == CountWidth'(k)) begin
				acc_wide[k*GroupBits +: GroupBits] = in_byte[GroupBits-1:0];
			end
		end
	end

	assign acc_ins    = acc_wide[ValueWidth-1:0] | acc_eff;
	assign dec_sum    = acc_ins + (delta_q ? prev_eff : '0);
	assign dec_result = dec_acc && (overflow || dec_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= 1'b0;
		end else if (cfg_we) begin
			delta_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (enc_load) begin
			prev_q <= value;
			acc_q  <= acc_eff;
			cnt_q  <= cnt_eff;
		end else if (dec_acc) begin
			priority if (overflow) begin
				prev_q <= prev_eff;
				acc_q  <= '0;
				cnt_q  <= '0;
			end else if (dec_final) begin
				prev_q <= dec_sum;
				acc_q  <= '0;
				cnt_q  <= '0;
			end else begin
				prev_q <= prev_eff;
				acc_q  <= acc_ins;
				cnt_q  <= cnt_eff + CountWidth'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enc_adv || dec_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_adv) begin
			out_byte_q    <= enc_byte;
			byte_valid_q  <= 1'b1;
			byte_last_q   <= stat.last;
			value_out_q   <= '0;
			value_valid_q <= 1'b0;
			error_q       <= 1'b0;
		end else if (dec_result) begin
			out_byte_q    <= '0;
			byte_valid_q  <= 1'b0;
			byte_last_q   <= 1'b0;
			value_out_q   <= overflow ? '0 : dec_sum;
			value_valid_q <= !overflow;
			error_q       <= overflow;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = byte_valid_q;
	assign byte_last   = byte_last_q;
	assign value_out   = value_out_q;
	assign value_valid = value_valid_q;
	assign error       = error_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountWidth'(MaxGroups)) else $error("group count past ten");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !stat.busy) else $error("request taken while serializer busy");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot({byte_valid_q, value_valid_q, error_q}))
		else $error("result carries more than one kind");
`endif

endmodule
